>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros assume a clock named clk_i
// and an active-low reset named rst_ni in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WFD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wfd assertion failed");
`define WFD_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define WFD_ASSERT(name, prop)
`define WFD_ASSERT_MSG(name, prop, msg)
`endif
`endif

>>> rtl/wfd_pkg.sv
`default_nettype none
package wfd_pkg;

  // Configuration register map.
  localparam int CFG_IDX_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_STEP = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAST_STEP = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH     = 8'd2;

  localparam logic [31:0] RST_SLOW_STEP = 32'd20802;
  localparam logic [31:0] RST_FAST_STEP = 32'd465282;
  localparam logic [23:0] RST_DEPTH     = 24'd8178893;

  // Modulation arithmetic.
  localparam logic signed [17:0] MIX_SLOW     = 18'sd47841;
  localparam logic signed [17:0] MIX_FAST     = 18'sd17695;
  localparam logic [33:0]        BIAS_Q31     = 34'd2254857830;
  localparam logic [15:0]        BYPASS_LIMIT = 16'd7;

  // Quarter-wave sine table.
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
  localparam longint SINE_DIV = 2 * SINE_ENTRIES;
  localparam longint Q30_ONE  = 64'sd1073741824;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef logic [15:0] sine_rom_t [SINE_ENTRIES];

  function automatic logic [15:0] quarter_sine(input int unsigned k);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint r;
    x    = longint'(k) * PI_Q30 / SINE_DIV;
    x2   = x * x / Q30_ONE;
    term = x;
    sum  = x;
    for (int n = 0; n < 7; n++) begin
      term = -term * x2 / Q30_ONE;
      term = term / TAYLOR_DIV[n];
      sum  = sum + term;
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 16384) / 32768;
    if (r > 32767) begin
      r = 32767;
    end
    return 16'(r);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_IDX_W,
    ST_SIN_W,
    ST_SIN_F,
    ST_MIX,
    ST_MULT,
    ST_DLY,
    ST_POS,
    ST_RD_A,
    ST_RD_B,
    ST_ACC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;      // capture the input word
    logic advance;   // step phases, write the rings, scale depth
    logic idx_en;    // form a sine table index
    logic idx_sel;   // 0: wow phase, 1: flutter phase
    logic sin_w_en;
    logic sin_f_en;
    logic mixa_en;
    logic mixb_en;
    logic mult_en;
    logic dly_en;
    logic pos_en;
    logic rd_en;
    logic rd_sel_b;  // 0: read tap A, 1: read tap B
    logic term_en;
    logic acc_en;
    logic finish;    // load the output register, advance the write pointer
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/wfd_ram.sv
`default_nettype none
module wfd_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/wfd_ctrl.sv
`default_nettype none
module wfd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire wfd_pkg::status_t status_i,
  output wfd_pkg::cmd_t         cmd_o
);
  import wfd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd_o.advance = 1'b1;
        state_d = status_i.bypass ? ST_FIN : ST_IDX_W;
      end
      ST_IDX_W: begin
        cmd_o.idx_en = 1'b1;
        state_d = ST_SIN_W;
      end
      ST_SIN_W: begin
        // Look up the wow sine while the flutter index is formed.
        cmd_o.sin_w_en = 1'b1;
        cmd_o.idx_en   = 1'b1;
        cmd_o.idx_sel  = 1'b1;
        state_d = ST_SIN_F;
      end
      ST_SIN_F: begin
        cmd_o.sin_f_en = 1'b1;
        cmd_o.mixa_en  = 1'b1;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mixb_en = 1'b1;
        state_d = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mult_en = 1'b1;
        state_d = ST_DLY;
      end
      ST_DLY: begin
        cmd_o.dly_en = 1'b1;
        state_d = ST_POS;
      end
      ST_POS: begin
        cmd_o.pos_en = 1'b1;
        state_d = ST_RD_A;
      end
      ST_RD_A: begin
        cmd_o.rd_en = 1'b1;
        state_d = ST_RD_B;
      end
      ST_RD_B: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel_b = 1'b1;
        cmd_o.term_en  = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/wfd_datapath.sv
`default_nettype none
`include "assert_macros.svh"
module wfd_datapath #(
  parameter int LINE_DEPTH  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire wfd_pkg::cmd_t                       cmd_i,
  output wfd_pkg::status_t                         status_o,
  input  wire logic signed [SAMPLE_BITS-1:0]       left_in_i,
  input  wire logic signed [SAMPLE_BITS-1:0]       right_in_i,
  input  wire logic        [15:0]                  wow_amount_i,
  input  wire logic                                cfg_valid_i,
  input  wire logic        [wfd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic        [31:0]                  cfg_data_i,
  input  wire logic                                out_stall_i,
  output logic                                     out_valid_o,
  output logic signed      [SAMPLE_BITS-1:0]       left_out_o,
  output logic signed      [SAMPLE_BITS-1:0]       right_out_o
);
  import wfd_pkg::*;

  localparam int AW   = $clog2(LINE_DEPTH);
  localparam int PW   = AW + 16;
  localparam int AccW = SAMPLE_BITS + 18;
  localparam logic [AW-1:0] LastAddr = AW'(LINE_DEPTH - 1);
  localparam logic [PW-1:0] MaxDelay = {AW'(LINE_DEPTH - 1), 16'd0};
  localparam logic [PW:0]   LineSpan = {(AW + 1)'(LINE_DEPTH), 16'd0};

  // Configuration registers.
  logic [31:0] slow_step_q, fast_step_q;
  logic [23:0] depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_step_q <= RST_SLOW_STEP;
      fast_step_q <= RST_FAST_STEP;
      depth_q     <= RST_DEPTH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SLOW_STEP: slow_step_q <= cfg_data_i;
        REG_FAST_STEP: fast_step_q <= cfg_data_i;
        REG_DEPTH:     depth_q     <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Captured input word.
  logic signed [SAMPLE_BITS-1:0] l_q, r_q;
  logic        [15:0]            wow_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      l_q   <= left_in_i;
      r_q   <= right_in_i;
      wow_q <= wow_amount_i;
    end
  end

  // Phases, write pointer and fill tracking.
  logic [31:0]   wow_phase_q, flut_phase_q;
  logic [AW-1:0] w_q;
  logic          wrapped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wow_phase_q  <= '0;
      flut_phase_q <= '0;
      w_q          <= '0;
      wrapped_q    <= 1'b0;
    end else begin
      if (cmd_i.advance) begin
        wow_phase_q  <= wow_phase_q + slow_step_q;
        flut_phase_q <= flut_phase_q + fast_step_q;
      end
      if (cmd_i.finish) begin
        if (w_q == LastAddr) begin
          w_q       <= '0;
          wrapped_q <= 1'b1;
        end else begin
          w_q <= w_q + 1'b1;
        end
      end
    end
  end

  // Depth scaled by the wow amount, Q8.16.
  logic [39:0] dw_prod;
  logic [23:0] dw_q;
  assign dw_prod = 40'(depth_q) * 40'(wow_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      dw_q <= dw_prod[39:16];
    end
  end

  // Sine lookup shared by both phases: index first, table read next cycle.
  logic [31:0]          phase_sel;
  logic [SINE_BITS-1:0] k_sel;
  logic [SINE_BITS:0]   idx_d, idx_q;
  logic                 neg_q;
  logic [15:0]          sine_mag;
  logic signed [15:0]   sine_val;
  logic signed [15:0]   ws_q, fs_q;

  assign phase_sel = cmd_i.idx_sel ? flut_phase_q : wow_phase_q;
  assign k_sel     = phase_sel[29 -: SINE_BITS];
  assign idx_d     = phase_sel[30] ? (SINE_BITS + 1)'(SINE_ENTRIES) - {1'b0, k_sel}
                                   : {1'b0, k_sel};

  // The falling edge of a quadrant can land one past the table, at full scale.
  assign sine_mag = idx_q[SINE_BITS] ? 16'd32767 : SINE_ROM[idx_q[SINE_BITS-1:0]];
  assign sine_val = neg_q ? -$signed(sine_mag) : $signed(sine_mag);

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_en) begin
      idx_q <= idx_d;
      neg_q <= phase_sel[31];
    end
    if (cmd_i.sin_w_en) begin
      ws_q <= sine_val;
    end
    if (cmd_i.sin_f_en) begin
      fs_q <= sine_val;
    end
  end

  // Mix and bias: f is always positive and below 2^33.
  logic [33:0] f_acc_q;
  logic [32:0] fmod_q;
  logic [39:0] pl_q;
  logic [40:0] ph_q;
  logic [56:0] dly_sum;
  logic [26:0] raw_delay;
  logic [PW-1:0] delay_q;

  assign dly_sum   = {ph_q, 16'd0} + 57'(pl_q);
  assign raw_delay = 27'(dly_sum[56:31]) + 27'd65536;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mixa_en) begin
      f_acc_q <= BIAS_Q31 + 34'(ws_q) * 34'(MIX_SLOW);
    end
    if (cmd_i.mixb_en) begin
      fmod_q <= 33'(f_acc_q + 34'(fs_q) * 34'(MIX_FAST));
    end
    // The 24 x 33 product is split in two halves of f.
    if (cmd_i.mult_en) begin
      pl_q <= 40'(dw_q) * 40'(fmod_q[15:0]);
      ph_q <= 41'(dw_q) * 41'(fmod_q[32:16]);
    end
    if (cmd_i.dly_en) begin
      delay_q <= (40'(raw_delay) > 40'(MaxDelay)) ? MaxDelay : PW'(raw_delay);
    end
  end

  // Read position behind the write pointer, wrapped into the ring.
  logic [PW:0]   pos_diff, pos;
  logic [AW-1:0] pos_a;
  logic [AW-1:0] a_q, b_q;
  logic [15:0]   frac_q;

  assign pos_diff = {1'b0, w_q, 16'd0} - {1'b0, delay_q};
  assign pos      = pos_diff[PW] ? pos_diff + LineSpan : pos_diff;
  assign pos_a    = pos[PW-1:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_en) begin
      a_q    <= pos_a;
      frac_q <= pos[15:0];
      b_q    <= (pos_a == LastAddr) ? '0 : pos_a + 1'b1;
    end
  end

  // Delay rings. Entries not yet written since reset read as zero.
  logic [AW-1:0]          raddr;
  logic [SAMPLE_BITS-1:0] rdata_l, rdata_r;
  logic                   rd_vld_q;

  assign raddr = cmd_i.rd_sel_b ? b_q : a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_vld_q <= wrapped_q || (raddr <= w_q);
    end
  end

  wfd_ram #(
    .Width(SAMPLE_BITS),
    .Depth(LINE_DEPTH)
  ) u_left_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.advance),
    .waddr_i(w_q),
    .wdata_i(l_q),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata_l)
  );

  wfd_ram #(
    .Width(SAMPLE_BITS),
    .Depth(LINE_DEPTH)
  ) u_right_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.advance),
    .waddr_i(w_q),
    .wdata_i(r_q),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata_r)
  );

  // Linear interpolation, rounded half up.
  logic signed [SAMPLE_BITS-1:0] samp_l, samp_r;
  logic signed [17:0]            coef_a, coef_b;
  logic signed [AccW-1:0]        lterm_q, rterm_q;
  logic signed [AccW-1:0]        lacc, racc;
  logic signed [SAMPLE_BITS-1:0] lres_q, rres_q;

  assign samp_l = rd_vld_q ? $signed(rdata_l) : '0;
  assign samp_r = rd_vld_q ? $signed(rdata_r) : '0;
  assign coef_a = $signed({1'b0, 17'(17'd65536 - {1'b0, frac_q})});
  assign coef_b = $signed({2'b00, frac_q});
  assign lacc   = lterm_q + AccW'(samp_l) * AccW'(coef_b) + AccW'(32768);
  assign racc   = rterm_q + AccW'(samp_r) * AccW'(coef_b) + AccW'(32768);

  always_ff @(posedge clk_i) begin
    if (cmd_i.term_en) begin
      lterm_q <= AccW'(samp_l) * AccW'(coef_a);
      rterm_q <= AccW'(samp_r) * AccW'(coef_a);
    end
    if (cmd_i.acc_en) begin
      lres_q <= lacc[SAMPLE_BITS+15:16];
      rres_q <= racc[SAMPLE_BITS+15:16];
    end
  end

  // Output register.
  logic                          out_vld_q;
  logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;
  logic                          bypass;

  assign bypass = wow_q < BYPASS_LIMIT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      left_out_q  <= bypass ? l_q : lres_q;
      right_out_q <= bypass ? r_q : rres_q;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign left_out_o        = left_out_q;
  assign right_out_o       = right_out_q;
  assign status_o.bypass   = bypass;
  assign status_o.out_free = !out_vld_q || !out_stall_i;

  `WFD_ASSERT_MSG(a_tap_a_behind_write, (cmd_i.rd_en && !cmd_i.rd_sel_b) |-> (a_q != w_q),
    "first tap reads the slot being written")
  `WFD_ASSERT(a_delay_in_range,
    cmd_i.pos_en |-> ((delay_q >= PW'(65536)) && (delay_q <= MaxDelay)))
  `WFD_ASSERT_MSG(a_finish_when_free, cmd_i.finish |-> (!out_vld_q || !out_stall_i),
    "output register overwritten while stalled")
  `WFD_ASSERT(a_wrap_sticky, wrapped_q |=> wrapped_q)

endmodule
`default_nettype wire

>>> rtl/wow_flutter_modulated_delay_top.sv
// Channel   Direction  Handshake             Contents
// input     in         in_valid_i/in_stall_o left_in_i, right_in_i, wow_amount_i
// output    out        out_valid_o/out_stall_i left_out_o, right_out_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A frame walks the sequencer from ADV through ACC to FIN, which loads the
// output register, or only ADV and FIN in bypass; the next frame can be taken
// in the cycle after FIN: one shared sine lookup and one port pair per ring are
// walked in turn. Reset clears phases, write pointer and fill tracking; ring
// slots not yet written read as zero. A new frame is accepted while the previous
// result waits in the output register; FIN waits while that is full and stalled.
`default_nettype none
module wow_flutter_modulated_delay_top #(
  parameter int LINE_DEPTH  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]           left_in_i,
  input  wire logic signed [SAMPLE_BITS-1:0]           right_in_i,
  input  wire logic        [15:0]                      wow_amount_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic signed      [SAMPLE_BITS-1:0]           left_out_o,
  output logic signed      [SAMPLE_BITS-1:0]           right_out_o,
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic        [wfd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic        [31:0]                      cfg_data_i
);
  import wfd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Registers are plain flops, so a write word is always taken.
  assign cfg_ready_o = 1'b1;

  wfd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  wfd_datapath #(
    .LINE_DEPTH (LINE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .wow_amount_i(wow_amount_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

endmodule
`default_nettype wire
